@@ design/sfis_pkg.sv @@
// Shared types and constants for the smallest-five index selector.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package sfis_pkg;

  localparam int PICK_COUNT = 5;
  localparam int MAX_LEN    = 65536;
  localparam int VALUE_W    = 26;
  localparam int POS_W      = 16;
  localparam int RUN_POS_W  = $clog2(MAX_LEN) + 1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
  } entry_t;

  typedef struct packed {
    entry_t [PICK_COUNT-1:0] ent;
    logic   [PICK_COUNT-1:0] vld;
  } list_t;

endpackage

@@ design/sfis_insert.sv @@
// Sorted insert of one value into the kept list, all slots compared at once.
// Depends on sfis_pkg.
`timescale 1ns / 1ps

module sfis_insert (
  input  sfis_pkg::list_t                 cur,
  input  logic [sfis_pkg::VALUE_W-1:0]    value,
  input  logic [sfis_pkg::POS_W-1:0]      pos,
  input  logic                            en,
  output sfis_pkg::list_t                 res
);

  logic [sfis_pkg::PICK_COUNT-1:0] le;
  sfis_pkg::list_t                 ins;
  sfis_pkg::entry_t                new_ent;

  assign new_ent.value = value;
  assign new_ent.pos   = pos;

  genvar i;
  generate
    for (i = 0; i < sfis_pkg::PICK_COUNT; i++) begin : g_slot
      assign le[i] = cur.vld[i] && (cur.ent[i].value <= value);
      if (i == 0) begin : g_first
        assign ins.ent[i] = le[i] ? cur.ent[i] : new_ent;
        assign ins.vld[i] = 1'b1;
      end else begin : g_rest
        assign ins.ent[i] = le[i] ? cur.ent[i] : (le[i-1] ? new_ent : cur.ent[i-1]);
        assign ins.vld[i] = cur.vld[i] | cur.vld[i-1];
      end
    end
  endgenerate

  assign res = en ? ins : cur;

endmodule

@@ design/sfis_keep.sv @@
// Kept-list registers and run position counter for the current run.
// Depends on sfis_pkg and sfis_insert.
`timescale 1ns / 1ps

module sfis_keep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          last,
  input  logic [sfis_pkg::VALUE_W-1:0]  value,
  output sfis_pkg::list_t               list_post,
  output logic                          load
);

  sfis_pkg::list_t                  list_r, list_nxt;
  logic [sfis_pkg::RUN_POS_W-1:0]   pos_r, pos_nxt;
  logic                             in_range;

  assign in_range = pos_r < sfis_pkg::RUN_POS_W'(sfis_pkg::MAX_LEN);

  sfis_insert u_insert (
    .cur   (list_r),
    .value (value),
    .pos   (pos_r[sfis_pkg::POS_W-1:0]),
    .en    (step && in_range),
    .res   (list_post)
  );

  assign load = step && last;

  always_comb begin
    list_nxt = list_r;
    pos_nxt  = pos_r;
    if (step) begin
      list_nxt = list_post;
      if (in_range) begin
        pos_nxt = pos_r + sfis_pkg::RUN_POS_W'(1);
      end
      if (last) begin
        list_nxt.vld = '0;
        pos_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_r.vld <= '0;
      pos_r      <= '0;
    end else begin
      list_r <= list_nxt;
      pos_r  <= pos_nxt;
    end
  end

endmodule

@@ design/sfis_drain.sv @@
// Result buffer: takes a finished list and shifts it out one word per cycle while out_stall is low.
// Depends on sfis_pkg.
`timescale 1ns / 1ps

module sfis_drain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  sfis_pkg::list_t               list_in,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfis_pkg::POS_W-1:0]    out_position,
  output logic [sfis_pkg::VALUE_W-1:0]  out_chosen_value,
  output logic                          out_final_pick
);

  sfis_pkg::list_t                 buf_r, buf_nxt;
  logic [sfis_pkg::PICK_COUNT:0]   vld_ext;
  logic                            take;

  assign vld_ext          = {1'b0, buf_r.vld};
  assign take             = out_valid && !out_stall;
  assign free             = !buf_r.vld[0] || (take && !vld_ext[1]);
  assign out_valid        = buf_r.vld[0];
  assign out_position     = buf_r.ent[0].pos;
  assign out_chosen_value = buf_r.ent[0].value;
  assign out_final_pick   = !vld_ext[1];

  always_comb begin
    buf_nxt = buf_r;
    if (load) begin
      buf_nxt = list_in;
    end else if (take) begin
      for (int i = 0; i < sfis_pkg::PICK_COUNT - 1; i++) begin
        buf_nxt.ent[i] = buf_r.ent[i+1];
      end
      buf_nxt.vld = vld_ext[sfis_pkg::PICK_COUNT:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r.vld <= '0;
    end else begin
      buf_r <= buf_nxt;
    end
  end

endmodule

@@ design/smallest_five_index_selector.sv @@
// Top level of the smallest-five index selector: input register, kept list, result buffer.
// Depends on sfis_pkg, sfis_keep and sfis_drain.
//
// Usage:
//   Input channel (in_valid / in_stall): one distance word per accepted cycle, with
//   in_end_of_run high on the last word of a run. Words are numbered from 0 within a run;
//   words at position MAX_LEN or later are counted out of the selection.
//   Result channel (out_valid / out_stall): after the marked word, the kept entries
//   (up to five) come out in ascending value order, ties by lower position, one word per
//   accepted cycle; out_final_pick marks the last one of the run.
//   Throughput: one input word per cycle. A marked word waits in the input register while
//   the previous run's results still drain, so back-to-back runs of fewer words than
//   results briefly stall the input.
//   Order: an accepted word is registered in the input register and is merged into the kept
//   list as it leaves it; a marked word hands the merged list straight to the result buffer.
//   Reset (rst_n low, synchronous): empties the input register, kept list, run counter
//   and result buffer. No clearing pass is needed.
//   Receiver stall: the current result holds; the list of the next run keeps filling,
//   and only a new marked word is held back until the buffer frees.
`timescale 1ns / 1ps

module smallest_five_index_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfis_pkg::VALUE_W-1:0]  in_distance,
  input  logic                          in_end_of_run,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfis_pkg::POS_W-1:0]    out_position,
  output logic [sfis_pkg::VALUE_W-1:0]  out_chosen_value,
  output logic                          out_final_pick
);

  logic                          s1_valid_r, s1_valid_nxt;
  logic [sfis_pkg::VALUE_W-1:0]  s1_value_r;
  logic                          s1_end_r;
  logic                          accept, adv, drain_free, load;
  sfis_pkg::list_t               list_post;
  logic [sfis_pkg::PICK_COUNT:0] vld_chk;

  assign adv      = s1_valid_r && (!s1_end_r || drain_free);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value_r <= in_distance;
      s1_end_r   <= in_end_of_run;
    end
  end

  sfis_keep u_keep (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .last      (s1_end_r),
    .value     (s1_value_r),
    .list_post (list_post),
    .load      (load)
  );

  sfis_drain u_drain (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .list_in          (list_post),
    .free             (drain_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_chosen_value (out_chosen_value),
    .out_final_pick   (out_final_pick)
  );

  assign vld_chk = {1'b0, list_post.vld} + (sfis_pkg::PICK_COUNT + 1)'(1);

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> drain_free)
    else $error("list handed over while result buffer busy");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_prefix_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(vld_chk))
    else $error("kept list valid bits are not a prefix");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    load && list_post.vld[0] |=> out_valid)
    else $error("loaded list did not appear on the result channel");

endmodule

@@ tb/tb_smallest_five_index_selector.sv @@
// Self-checking testbench for smallest_five_index_selector: streams runs of distance
// words, predicts the five smallest per run and checks every result word in order.
// Depends on sfis_pkg and the smallest_five_index_selector RTL.
`timescale 1ns / 1ps

module tb_smallest_five_index_selector;

  typedef logic [sfis_pkg::VALUE_W-1:0]   dist_t;
  typedef logic [sfis_pkg::POS_W-1:0]     pos_t;
  typedef logic [sfis_pkg::RUN_POS_W-1:0] run_pos_t;

  typedef struct packed {
    pos_t  position;
    dist_t value;
    logic  final_pick;
  } pick_t;

  localparam dist_t MAX_DIST = '1;

  class pick_scoreboard;
    dist_t    kept_dist[sfis_pkg::PICK_COUNT];
    run_pos_t kept_pos[sfis_pkg::PICK_COUNT];
    int       kept_n;
    run_pos_t next_pos;
    pick_t    picks_due[$];
    int       mismatches;

    function new();
      clear_run();
      mismatches = 0;
    endfunction

    function void clear_run();
      for (int i = 0; i < sfis_pkg::PICK_COUNT; i++) begin
        kept_dist[i] = '0;
        kept_pos[i]  = '0;
      end
      kept_n   = 0;
      next_pos = '0;
    endfunction

    function int pending();
      return picks_due.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Insert after every kept entry with a value not above d, so ties keep the earlier word.
    function void keep_smallest(dist_t d, run_pos_t p);
      int slot;
      int i;
      slot = 0;
      while (slot < kept_n && kept_dist[slot] <= d) slot++;
      if (slot >= sfis_pkg::PICK_COUNT) return;
      i = (kept_n < sfis_pkg::PICK_COUNT) ? kept_n : sfis_pkg::PICK_COUNT - 1;
      while (i > slot) begin
        kept_dist[i] = kept_dist[i-1];
        kept_pos[i]  = kept_pos[i-1];
        i--;
      end
      kept_dist[slot] = d;
      kept_pos[slot]  = p;
      if (kept_n < sfis_pkg::PICK_COUNT) kept_n++;
    endfunction

    function void note_word(dist_t d, logic eor);
      pick_t p;
      if (next_pos < sfis_pkg::MAX_LEN) begin
        keep_smallest(d, next_pos);
        next_pos++;
      end
      if (eor) begin
        for (int k = 0; k < kept_n; k++) begin
          p.position   = kept_pos[k][sfis_pkg::POS_W-1:0];
          p.value      = kept_dist[k];
          p.final_pick = (k == kept_n - 1);
          picks_due.push_back(p);
        end
        clear_run();
      end
    endfunction

    function void check_pick(pos_t pos, dist_t val, logic fin);
      pick_t want;
      if (picks_due.size() == 0) begin
        flag($sformatf("unexpected result word: pos %0d value %0d final %0b", pos, val, fin));
      end else begin
        want = picks_due.pop_front();
        if (want.position !== pos || want.value !== val || want.final_pick !== fin)
          flag($sformatf({"result mismatch: expected pos %0d value %0d final %0b,",
                          " got pos %0d value %0d final %0b"},
                         want.position, want.value, want.final_pick, pos, val, fin));
      end
    endfunction
  endclass

  logic  clk;
  logic  rst_n         = 1'b0;
  logic  in_valid      = 1'b0;
  logic  in_stall;
  dist_t in_distance   = '0;
  logic  in_end_of_run = 1'b0;
  logic  out_valid;
  logic  out_stall     = 1'b0;
  pos_t  out_position;
  dist_t out_chosen_value;
  logic  out_final_pick;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  pick_scoreboard sb = new();

  smallest_five_index_selector dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_distance      (in_distance),
    .in_end_of_run    (in_end_of_run),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_chosen_value (out_chosen_value),
    .out_final_pick   (out_final_pick)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #7_200_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pick(out_position, out_chosen_value, out_final_pick);
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_word(dist_t d, logic eor);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_distance   <= d;
    in_end_of_run <= eor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(d, eor);
  endtask

  task automatic send_list(dist_t vals[$]);
    foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
  endtask

  function automatic dist_t rand_dist();
    case ($urandom_range(0, 3))
      0:       return dist_t'($urandom_range(0, 7));
      1:       return MAX_DIST - dist_t'($urandom_range(0, 7));
      default: return dist_t'($urandom);
    endcase
  endfunction

  task automatic send_random_run(int len);
    for (int i = 0; i < len; i++) send_word(rand_dist(), i == len - 1);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin
    int    sent;
    int    len;
    dist_t run_q[$];

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(MAX_DIST, 1'b1);
    send_word('0, 1'b1);
    run_q = '{MAX_DIST, 26'd0};
    send_list(run_q);
    run_q = '{26'd7, 26'd7, 26'd7, 26'd3};
    send_list(run_q);
    run_q = '{26'd5, 26'd4, 26'd3, 26'd2, 26'd1};
    send_list(run_q);
    run_q = '{26'd9, 26'd1, 26'd9, 26'd9, 26'd9, 26'd9, 26'd0};
    send_list(run_q);
    run_q = '{26'd0, 26'd0, 26'd0, 26'd0, 26'd0, 26'd0};
    send_list(run_q);
    drain_all();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      sent = 0;
      while (sent < 96) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        send_random_run(len);
        sent += len;
      end
      // hold the sender until every result word has drained
      drain_all();
    end

    recv_stall_pct = 0;
    drain_all();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
